/* sv/lsbs_pkg.sv */
`timescale 1ns / 1ps
// types and constants shared by the lit surface block shader
// no dependencies
package lsbs_pkg;

  // request kinds carried on the slave-side tuser
  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_START = 2'd1,
    REQ_TEXEL = 2'd2
  } req_type_t;

  // configuration register indexes
  localparam logic REG_MIP_LEVEL = 1'b0;

  // integer part of an 8.8 light value
  localparam logic [15:0] LIGHT_ROW_MASK = 16'hFF00;

  localparam int LIGHT_W = 16;

  // one finished word on the master side
  typedef struct packed {
    logic       block_end;
    logic       row_end;
    logic [7:0] lit_pixel;
  } result_t;

endpackage

/* sv/lit_surface_block_shader.sv */
`timescale 1ns / 1ps
// lit surface block shader: bilinear light walk plus colormap lookup
// depends on lsbs_pkg
// a texel word passes the colormap read register, then the output queue, to the master side
// throughput: one word per cycle; the single-port colormap memory is used once per word
// (a load writes it, a texel reads it), input stalls once read stage plus queue hold three
// reset: synchronous, clears lights, steps, counters, mip level and the output queue;
// the colormap memory is not cleared and holds garbage until loaded
module lit_surface_block_shader #(
  parameter int LIGHT_ROWS     = 64,
  parameter int MAX_BLOCK_SIDE = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  // slave side
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // [13:0] map_address, [21:14] map_value, [35:22] light_top_left,
  // [49:36] light_top_right, [63:50] light_bottom_left,
  // [77:64] light_bottom_right, [85:78] texel, [87:86] zero
  input  logic [87:0]              s_tdata,
  // [1:0] req_type
  input  logic [1:0]               s_tuser,
  // master side
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // [7:0] lit_pixel
  output logic [7:0]               m_tdata,
  // [0] row_end
  output logic [0:0]               m_tuser,
  // block_end
  output logic                     m_tlast,
  // configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import lsbs_pkg::*;

  localparam int ROW_W      = (LIGHT_ROWS > 1) ? $clog2(LIGHT_ROWS) : 1;
  localparam int ADDR_W     = ROW_W + 8;
  localparam int TABLE_SIZE = LIGHT_ROWS * 256;
  localparam int CNT_W      = $clog2(MAX_BLOCK_SIDE);
  localparam int SIDE_W     = $clog2(MAX_BLOCK_SIDE + 1);
  localparam int SIDE_LOG   = SIDE_W - 1;
  localparam int QDEPTH     = 3;

  // ---------------- configuration ----------------
  logic [1:0] mip_level;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_MIP_LEVEL);

  always_ff @(posedge clk) begin
    if (rst) begin
      mip_level <= 2'd0;
    end else if (cfg_write) begin
      mip_level <= pwdata[1:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_MIP_LEVEL) begin
      prdata = {30'd0, mip_level};
    end
  end

  // ---------------- input fields ----------------
  req_type_t    req;
  logic [13:0]  map_address;
  logic [7:0]   map_value;
  logic [13:0]  light_top_left;
  logic [13:0]  light_top_right;
  logic [13:0]  light_bottom_left;
  logic [13:0]  light_bottom_right;
  logic [7:0]   texel;

  assign req                = req_type_t'(s_tuser);
  assign map_address        = s_tdata[13:0];
  assign map_value          = s_tdata[21:14];
  assign light_top_left     = s_tdata[35:22];
  assign light_top_right    = s_tdata[49:36];
  assign light_bottom_left  = s_tdata[63:50];
  assign light_bottom_right = s_tdata[77:64];
  assign texel              = s_tdata[85:78];

  logic accept;
  assign accept = s_tvalid && s_tready;

  // ---------------- block geometry ----------------
  logic [SIDE_W-1:0] side_raw;
  logic [CNT_W-1:0]  side_m1;
  logic [2:0]        step_shift;
  logic              from_right;

  always_comb begin
    side_raw = SIDE_W'(MAX_BLOCK_SIDE) >> mip_level;
    side_m1  = (side_raw == '0) ? '0 : CNT_W'(side_raw - SIDE_W'(1));
    if (32'(mip_level) >= SIDE_LOG) begin
      step_shift = 3'd0;
    end else begin
      step_shift = 3'(SIDE_LOG - 32'(mip_level));
    end
    from_right = (mip_level == 2'd3);
  end

  // ---------------- light walk state ----------------
  logic [LIGHT_W-1:0] edge_light_left, edge_light_right;
  logic [LIGHT_W-1:0] edge_step_left, edge_step_right;
  logic [LIGHT_W-1:0] pixel_light;
  logic [CNT_W-1:0]   column_count, row_count;

  logic [LIGHT_W-1:0] row_diff, row_step, cur_light, pixel_light_next;
  logic [LIGHT_W-1:0] start_offset;
  logic [LIGHT_W-1:0] left_diff, right_diff;
  logic [7:0]         row_raw;
  logic [ROW_W-1:0]   light_row;
  logic               row_end, block_end;

  always_comb begin
    row_diff     = from_right ? (edge_light_left - edge_light_right)
                              : (edge_light_right - edge_light_left);
    row_step     = LIGHT_W'($signed(row_diff) >>> step_shift);
    start_offset = LIGHT_W'(row_step * LIGHT_W'(side_m1));
    if (column_count == '0) begin
      cur_light = from_right ? (edge_light_right + start_offset) : edge_light_left;
    end else begin
      cur_light = pixel_light;
    end
    pixel_light_next = from_right ? (cur_light - row_step) : (cur_light + row_step);

    row_raw = 8'((cur_light & LIGHT_ROW_MASK) >> 8);
    // rows past the end of the colormap saturate to the last row
    if (32'(row_raw) >= LIGHT_ROWS) begin
      light_row = ROW_W'(LIGHT_ROWS - 1);
    end else begin
      light_row = ROW_W'(row_raw);
    end

    row_end   = (column_count >= side_m1);
    block_end = row_end && (row_count >= side_m1);

    left_diff  = LIGHT_W'(light_bottom_left) - LIGHT_W'(light_top_left);
    right_diff = LIGHT_W'(light_bottom_right) - LIGHT_W'(light_top_right);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_light_left  <= '0;
      edge_light_right <= '0;
      edge_step_left   <= '0;
      edge_step_right  <= '0;
      pixel_light      <= '0;
      column_count     <= '0;
      row_count        <= '0;
    end else if (accept) begin
      case (req)
        REQ_START: begin
          edge_light_left  <= LIGHT_W'(light_top_left);
          edge_light_right <= LIGHT_W'(light_top_right);
          edge_step_left   <= LIGHT_W'($signed(left_diff) >>> step_shift);
          edge_step_right  <= LIGHT_W'($signed(right_diff) >>> step_shift);
          column_count     <= '0;
          row_count        <= '0;
        end
        REQ_TEXEL: begin
          pixel_light <= pixel_light_next;
          if (row_end) begin
            column_count     <= '0;
            edge_light_left  <= edge_light_left + edge_step_left;
            edge_light_right <= edge_light_right + edge_step_right;
            row_count        <= block_end ? '0 : row_count + CNT_W'(1);
          end else begin
            column_count <= column_count + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------- colormap memory ----------------
  logic [7:0]        shade_table [TABLE_SIZE];
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we;
  logic [7:0]        mem_rdata;

  always_comb begin
    mem_we   = accept && (req == REQ_LOAD) && (32'(map_address) < TABLE_SIZE);
    mem_addr = (req == REQ_LOAD) ? ADDR_W'(map_address) : {light_row, texel};
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      shade_table[mem_addr] <= map_value;
    end else begin
      mem_rdata <= shade_table[mem_addr];
    end
  end

  // ---------------- read stage ----------------
  logic s1_valid, s1_row_end, s1_block_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && (req == REQ_TEXEL);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_row_end   <= row_end;
      s1_block_end <= block_end;
    end
  end

  // ---------------- output queue ----------------
  result_t     res_q [QDEPTH];
  logic [1:0]  wr_ptr, rd_ptr;
  logic [1:0]  q_count;
  logic        q_push, q_pop;
  logic [2:0]  in_flight;
  result_t     head;

  assign q_push    = s1_valid;
  assign q_pop     = m_tvalid && m_tready;
  assign in_flight = 3'(q_count) + 3'(s1_valid);
  // a word may enter only when the queue can take it even if nothing drains
  assign s_tready  = (in_flight < 3'(QDEPTH));
  assign m_tvalid  = (q_count != 2'd0);
  assign head      = res_q[rd_ptr];
  assign m_tdata   = head.lit_pixel;
  assign m_tuser   = head.row_end;
  assign m_tlast   = head.block_end;

  always_ff @(posedge clk) begin
    if (q_push) begin
      res_q[wr_ptr] <= '{block_end: s1_block_end, row_end: s1_row_end,
                         lit_pixel: mem_rdata};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (q_push) begin
        wr_ptr <= (wr_ptr == 2'(QDEPTH - 1)) ? 2'd0 : wr_ptr + 2'd1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == 2'(QDEPTH - 1)) ? 2'd0 : rd_ptr + 2'd1;
      end
      q_count <= q_count + 2'(q_push) - 2'(q_pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (q_count <= 2'(QDEPTH - 1)))
    else $error("result queue has no room for a read word");

  a_block_end_row: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_block_end |-> s1_row_end)
    else $error("block end without row end");

  a_texel_read: assert property (@(posedge clk) disable iff (rst)
    accept && (req == REQ_TEXEL) |=> s1_valid)
    else $error("accepted texel produced no read");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    accept && (req == REQ_START) |=> (column_count == '0) && (row_count == '0))
    else $error("start word did not clear counters");
`endif

endmodule
